// ----- hw/rtl/hsv_pkg.sv -----
package hsv_pkg;

  localparam int HueW = 15;
  localparam int ChanW = 16;
  localparam int RemW = 12;

  localparam logic [HueW-1:0] HueFull = 15'd23040;
  localparam logic [HueW-1:0] SectorSpan = 15'd3840;

  // ceil(2^24 / 15): floor(x / 15) for x below 2^20 is (x * FracRecip) >> 24
  localparam logic [20:0] FracRecip = 21'd1118482;

  localparam logic [ChanW-1:0] Q16One = 16'hFFFF;

  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5,
    SEC_FULL    = 3'd6
  } sector_t;

endpackage

// ----- hw/rtl/hsv_if.sv -----
interface hsv_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsv_pkg::HueW-1:0]       hue;
  hsv_pkg::chan_t                 saturation;
  hsv_pkg::chan_t                 brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

interface hsv_out_if;
  logic           valid;
  logic           ready;
  hsv_pkg::chan_t red;
  hsv_pkg::chan_t green;
  hsv_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/hsv_to_rgb.sv -----
// HSV to RGB color converter.
// in_c carries one color per beat: hue in 1/64 degree (0..23040, larger values
// clamp to a full turn), saturation and brightness as unsigned Q0.16.
// out_c carries red, green and blue as unsigned Q0.16, one beat per input beat,
// in order. Both channels use valid/ready; a beat moves when both are high.
// Throughput: one color per cycle unless the receiver stalls, set by a
// five-stage pipeline in which no stage holds more than two parallel
// multiplies, none wider than 20x21 bits. Its stages, in order: sector split,
// fraction and p, s*f terms, q and t, channel routing into the output
// register.
// Zero saturation bypasses the math: all three outputs equal brightness.
// Reset (rst_n low, synchronous) clears every stage valid; no beat in flight
// survives it.
// When the receiver drops ready while a result is held, the whole pipeline
// freezes and in_c.ready drops with it; nothing is lost or repeated. While the
// output register is empty or being drained, a new beat is accepted each cycle.
module hsv_to_rgb (
  input  logic          clk,
  input  logic          rst_n,
  hsv_in_if.sink        in_c,
  hsv_out_if.source     out_c
);

  logic adv;

  // stage 1: clamp, sector, remainder
  logic                      vld1_r;
  hsv_pkg::sector_t          sec1_r, sec1_nxt;
  logic [hsv_pkg::RemW-1:0]  rem1_r, rem1_nxt;
  hsv_pkg::chan_t            sat1_r, val1_r;
  logic [hsv_pkg::HueW-1:0]  hue_c;
  logic [hsv_pkg::HueW-1:0]  rem_w;

  // stage 2: fraction and p
  logic                      vld2_r;
  hsv_pkg::sector_t          sec2_r;
  hsv_pkg::chan_t            sat2_r, val2_r, f2_r, p2_r;
  logic [40:0]               fprod;
  logic [31:0]               pprod;

  // stage 3: s*f and s*(1-f)
  logic                      vld3_r;
  hsv_pkg::sector_t          sec3_r;
  hsv_pkg::chan_t            sat3_r, val3_r, p3_r, sf3_r, sfi3_r;
  logic [31:0]               sfprod;
  logic [16:0]               finv;
  logic [32:0]               sfiprod;

  // stage 4: q and t
  logic                      vld4_r;
  hsv_pkg::sector_t          sec4_r;
  hsv_pkg::chan_t            sat4_r, val4_r, p4_r, q4_r, t4_r;
  logic [31:0]               qprod, tprod;

  // stage 5: output register
  logic                      out_vld_r;
  hsv_pkg::chan_t            red_r, grn_r, blu_r;
  hsv_pkg::chan_t            red_nxt, grn_nxt, blu_nxt;

  assign adv = !out_vld_r || out_c.ready;
  assign in_c.ready = adv;

  // ---- stage 1 ----
  always_comb begin
    hue_c = (in_c.hue > hsv_pkg::HueFull) ? hsv_pkg::HueFull : in_c.hue;
    if (hue_c >= 15'(6 * hsv_pkg::SectorSpan)) begin
      sec1_nxt = hsv_pkg::SEC_FULL;
      rem_w    = hue_c - 15'(6 * hsv_pkg::SectorSpan);
    end else if (hue_c >= 15'(5 * hsv_pkg::SectorSpan)) begin
      sec1_nxt = hsv_pkg::SEC_MAG_RED;
      rem_w    = hue_c - 15'(5 * hsv_pkg::SectorSpan);
    end else if (hue_c >= 15'(4 * hsv_pkg::SectorSpan)) begin
      sec1_nxt = hsv_pkg::SEC_BLU_MAG;
      rem_w    = hue_c - 15'(4 * hsv_pkg::SectorSpan);
    end else if (hue_c >= 15'(3 * hsv_pkg::SectorSpan)) begin
      sec1_nxt = hsv_pkg::SEC_CYN_BLU;
      rem_w    = hue_c - 15'(3 * hsv_pkg::SectorSpan);
    end else if (hue_c >= 15'(2 * hsv_pkg::SectorSpan)) begin
      sec1_nxt = hsv_pkg::SEC_GRN_CYN;
      rem_w    = hue_c - 15'(2 * hsv_pkg::SectorSpan);
    end else if (hue_c >= hsv_pkg::SectorSpan) begin
      sec1_nxt = hsv_pkg::SEC_YEL_GRN;
      rem_w    = hue_c - hsv_pkg::SectorSpan;
    end else begin
      sec1_nxt = hsv_pkg::SEC_RED_YEL;
      rem_w    = hue_c;
    end
    rem1_nxt = rem_w[hsv_pkg::RemW-1:0];
  end

  // ---- stage 2: f = floor(rem * 256 / 15) ----
  assign fprod = 41'({rem1_r, 8'd0}) * 41'(hsv_pkg::FracRecip);
  assign pprod = 32'(val1_r) * 32'(hsv_pkg::Q16One - sat1_r);

  // ---- stage 3 ----
  assign sfprod  = 32'(sat2_r) * 32'(f2_r);
  assign finv    = 17'h10000 - 17'(f2_r);
  assign sfiprod = 33'(sat2_r) * 33'(finv);

  // ---- stage 4 ----
  assign qprod = 32'(val3_r) * 32'(hsv_pkg::Q16One - sf3_r);
  assign tprod = 32'(val3_r) * 32'(hsv_pkg::Q16One - sfi3_r);

  // ---- stage 5: route by sector ----
  always_comb begin
    red_nxt = val4_r;
    grn_nxt = val4_r;
    blu_nxt = val4_r;
    if (sat4_r != '0) begin
      case (sec4_r) inside
        hsv_pkg::SEC_RED_YEL: begin
          red_nxt = val4_r; grn_nxt = t4_r;   blu_nxt = p4_r;
        end
        hsv_pkg::SEC_YEL_GRN: begin
          red_nxt = q4_r;   grn_nxt = val4_r; blu_nxt = p4_r;
        end
        hsv_pkg::SEC_GRN_CYN: begin
          red_nxt = p4_r;   grn_nxt = val4_r; blu_nxt = t4_r;
        end
        hsv_pkg::SEC_CYN_BLU: begin
          red_nxt = p4_r;   grn_nxt = q4_r;   blu_nxt = val4_r;
        end
        hsv_pkg::SEC_BLU_MAG: begin
          red_nxt = t4_r;   grn_nxt = p4_r;   blu_nxt = val4_r;
        end
        hsv_pkg::SEC_MAG_RED, hsv_pkg::SEC_FULL: begin
          red_nxt = val4_r; grn_nxt = p4_r;   blu_nxt = q4_r;
        end
        default: begin
          red_nxt = val4_r; grn_nxt = p4_r;   blu_nxt = q4_r;
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld1_r    <= in_c.valid;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      vld4_r    <= vld3_r;
      out_vld_r <= vld4_r;
    end
  end

  // payload: advance together, hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      sec1_r <= sec1_nxt;
      rem1_r <= rem1_nxt;
      sat1_r <= in_c.saturation;
      val1_r <= in_c.brightness;

      sec2_r <= sec1_r;
      sat2_r <= sat1_r;
      val2_r <= val1_r;
      f2_r   <= fprod[39:24];
      p2_r   <= pprod[31:16];

      sec3_r <= sec2_r;
      sat3_r <= sat2_r;
      val3_r <= val2_r;
      p3_r   <= p2_r;
      sf3_r  <= sfprod[31:16];
      sfi3_r <= sfiprod[31:16];

      sec4_r <= sec3_r;
      sat4_r <= sat3_r;
      val4_r <= val3_r;
      p4_r   <= p3_r;
      q4_r   <= qprod[31:16];
      t4_r   <= tprod[31:16];

      red_r  <= red_nxt;
      grn_r  <= grn_nxt;
      blu_r  <= blu_nxt;
    end
  end

  assign out_c.valid = out_vld_r;
  assign out_c.red   = red_r;
  assign out_c.green = grn_r;
  assign out_c.blue  = blu_r;

endmodule

// ----- tb/sv/hsv_to_rgb_test.sv -----
module hsv_to_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomColors = 1030;
  localparam int CalmTail = 150;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;

  typedef logic [hsv_pkg::HueW-1:0] hue_t;

  typedef struct packed {
    hsv_pkg::chan_t red;
    hsv_pkg::chan_t green;
    hsv_pkg::chan_t blue;
  } rgb_t;

  typedef struct packed {
    hue_t           hue;
    hsv_pkg::chan_t sat;
    hsv_pkg::chan_t val;
    logic           known;
    rgb_t           rgb;
  } color_row_t;

  localparam int TableLen = 20;

  // Rows with known set carry a hand-derived color; the rest go through the predictor.
  color_row_t color_table [TableLen] = '{
    '{15'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{15'd0,     16'd0,     16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
    '{15'd12345, 16'd0,     16'd40000, 1'b1, '{16'd40000, 16'd40000, 16'd40000}},
    '{15'd32767, 16'd0,     16'd1,     1'b1, '{16'd1,     16'd1,     16'd1}},
    '{15'd0,     16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd0}},
    '{15'd23040, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd65534}},
    '{15'd32767, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd65534}},
    '{15'd23041, 16'd65535, 16'd65535, 1'b1, '{16'd65535, 16'd0,     16'd65534}},
    '{15'd5000,  16'd65535, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{15'd3840,  16'd65535, 16'd65535, 1'b0, '0},
    '{15'd3839,  16'd65535, 16'd65535, 1'b0, '0},
    '{15'd7680,  16'd40000, 16'd50000, 1'b0, '0},
    '{15'd11520, 16'd1,     16'd65535, 1'b0, '0},
    '{15'd15360, 16'd32768, 16'd65535, 1'b0, '0},
    '{15'd19200, 16'd65535, 16'd30000, 1'b0, '0},
    '{15'd21000, 16'd20000, 16'd60000, 1'b0, '0},
    '{15'd1920,  16'd65535, 16'd65535, 1'b0, '0},
    '{15'd23039, 16'd65535, 16'd65535, 1'b0, '0},
    '{15'd16384, 16'd21845, 16'd43690, 1'b0, '0},
    '{15'd10922, 16'd43690, 16'd21845, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  hsv_in_if  in_c ();
  hsv_out_if out_c ();

  hsv_to_rgb dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_c  (in_c),
    .out_c (out_c)
  );

  rgb_t pending_rgb [$];
  int   fail_count;
  int   color_count;
  int   rgb_count;
  int   gray_count;
  int   clamp_count;
  int   cycle_count;
  int   idle_pct;
  bit   calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned scale_q16(longint unsigned a, longint unsigned b);
    return (a * b) >> 16;
  endfunction

  function automatic rgb_t convert_hsv(hue_t hue_in, hsv_pkg::chan_t sat,
                                       hsv_pkg::chan_t val);
    longint unsigned h, sec, rem, frac, v, s, p, q, t;
    rgb_t rgb;
    h = hue_in;
    s = sat;
    v = val;
    if (h > hsv_pkg::HueFull) h = hsv_pkg::HueFull;
    if (s == 0) begin
      rgb = '{val, val, val};
    end else begin
      sec  = h / hsv_pkg::SectorSpan;
      rem  = h % hsv_pkg::SectorSpan;
      frac = (rem << 16) / hsv_pkg::SectorSpan;
      p = scale_q16(v, hsv_pkg::Q16One - s);
      q = scale_q16(v, hsv_pkg::Q16One - scale_q16(s, frac));
      t = scale_q16(v, hsv_pkg::Q16One - scale_q16(s, 65536 - frac));
      case (hsv_pkg::sector_t'(sec[2:0]))
        hsv_pkg::SEC_RED_YEL: rgb = '{v[15:0], t[15:0], p[15:0]};
        hsv_pkg::SEC_YEL_GRN: rgb = '{q[15:0], v[15:0], p[15:0]};
        hsv_pkg::SEC_GRN_CYN: rgb = '{p[15:0], v[15:0], t[15:0]};
        hsv_pkg::SEC_CYN_BLU: rgb = '{p[15:0], q[15:0], v[15:0]};
        hsv_pkg::SEC_BLU_MAG: rgb = '{t[15:0], p[15:0], v[15:0]};
        default:              rgb = '{v[15:0], p[15:0], q[15:0]};
      endcase
    end
    return rgb;
  endfunction

  // Hold the beat until accepted, then log the color it must produce.
  task automatic send_color(hue_t hue, hsv_pkg::chan_t sat, hsv_pkg::chan_t val,
                            rgb_t rgb);
    in_c.valid      <= 1'b1;
    in_c.hue        <= hue;
    in_c.saturation <= sat;
    in_c.brightness <= val;
    do @(posedge clk); while (!in_c.ready);
    pending_rgb.push_back(rgb);
    color_count++;
    if (sat == 0) gray_count++;
    if (hue > hsv_pkg::HueFull) clamp_count++;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_c.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    hue_t           hue;
    hsv_pkg::chan_t sat;
    hsv_pkg::chan_t val;
    int             sec;
    in_c.valid      <= 1'b0;
    in_c.hue        <= '0;
    in_c.saturation <= '0;
    in_c.brightness <= '0;
    idle_pct = 30;
    calm     = 1'b0;
    rst_n    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (color_table[i]) begin
      send_color(color_table[i].hue, color_table[i].sat, color_table[i].val,
                 color_table[i].known ? color_table[i].rgb :
                 convert_hsv(color_table[i].hue, color_table[i].sat, color_table[i].val));
    end

    for (int n = 0; n < RandomColors; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 60;
        endcase
      end
      if (n >= RandomColors - CalmTail) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: hue = hsv_pkg::HueW'($urandom_range(23041, 32767));
        1: begin
          sec = $urandom_range(0, 6);
          hue = hsv_pkg::HueW'(sec * 3840 + $urandom_range(0, 2) - 1 + (sec == 0 ? 1 : 0));
        end
        default: hue = hsv_pkg::HueW'($urandom_range(0, 23040));
      endcase
      case ($urandom_range(0, 9))
        0:       sat = '0;
        1:       sat = hsv_pkg::Q16One;
        default: sat = hsv_pkg::chan_t'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = hsv_pkg::Q16One;
        default: val = hsv_pkg::chan_t'($urandom);
      endcase
      send_color(hue, sat, val, convert_hsv(hue, sat, val));
    end
    in_c.valid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Converted %0d colors (%0d directed), %0d gray, %0d with hue past a full turn.",
             color_count, TableLen, gray_count, clamp_count);
    $display("Checked %0d results under random input gaps and output stalls.", rgb_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    out_c.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_c.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_c.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_c.valid && out_c.ready) begin
      rgb_count++;
      if (pending_rgb.size() == 0) begin
        $error("unexpected beat: red %0d green %0d blue %0d",
               out_c.red, out_c.green, out_c.blue);
        fail_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (out_c.red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, out_c.red);
          fail_count++;
        end
        if (out_c.green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, out_c.green);
          fail_count++;
        end
        if (out_c.blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, out_c.blue);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_rgb.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
